// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, constants and codes shared by the first-fit heap allocator cells
// and its top level.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES    = 16384;
  localparam int HEADER_BYTES  = 16;
  localparam int GRANULE_BYTES = 64;
  localparam int MAX_SEGMENTS  = 256;
  localparam int FREE_DEPTH    = MAX_SEGMENTS + 1;

  localparam int OFS_W = 14;
  localparam int SUM_W = OFS_W + 1;
  localparam int CNT_W = $clog2(FREE_DEPTH);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ZERO,
    ST_NOFIT,
    ST_NULL,
    ST_NOTALLOC
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    FOP_NONE,
    FOP_SET_FIRST,
    FOP_SET_PRED,
    FOP_DEL_FIRST,
    FOP_SET_PRED_DEL,
    FOP_INS_FIRST
  } free_op_e;

  typedef enum logic [1:0] {
    UOP_NONE,
    UOP_APPEND,
    UOP_DEL
  } used_op_e;

  typedef struct packed {
    logic             command;
    logic [OFS_W-1:0] request_size;
    logic [OFS_W-1:0] payload_offset;
  } in_t;

  typedef struct packed {
    logic [OFS_W-1:0] result_offset;
    logic [2:0]       status;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] addr;
    logic [OFS_W-1:0] size;
  } seg_t;

  typedef struct packed {
    logic [OFS_W-1:0] addr;
    logic [OFS_W-1:0] size;
  } useg_t;

  typedef struct packed {
    logic             cmd;
    logic [SUM_W-1:0] need;
    logic [OFS_W-1:0] hdr;
    free_op_e         op;
    logic [OFS_W-1:0] wr_addr;
    logic [OFS_W-1:0] wr_size;
  } free_ctl_t;

  typedef struct packed {
    logic [OFS_W-1:0] hdr;
    logic [CNT_W-1:0] count;
    used_op_e         op;
    logic [OFS_W-1:0] wr_addr;
    logic [OFS_W-1:0] wr_size;
  } used_ctl_t;

  // first: first fit (allocate) or first segment at/after the block (free)
  // pred: last valid segment below the block
  typedef struct packed {
    logic             found;
    logic             fvalid;
    logic [OFS_W-1:0] faddr;
    logic [OFS_W-1:0] fsize;
    logic             pfound;
    logic [OFS_W-1:0] paddr;
    logic [OFS_W-1:0] psize;
  } free_carry_t;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] size;
  } used_carry_t;

endpackage

// ----- sv/ffha_free_cell.sv -----
// ----------------------------------------------------------------------------
// ffha_free_cell
// One entry of the address-ordered free list, with its link of the search
// carry chain and shift-in from both neighbors.
// ----------------------------------------------------------------------------
module ffha_free_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  is_head_i,
  input  ffha_pkg::free_ctl_t   ctl_i,
  input  ffha_pkg::seg_t        prev_seg_i,
  input  ffha_pkg::seg_t        next_seg_i,
  input  logic                  next_lt_i,
  input  ffha_pkg::free_carry_t carry_i,
  output ffha_pkg::free_carry_t carry_o,
  output ffha_pkg::seg_t        seg_o,
  output logic                  lt_o
);
  import ffha_pkg::*;

  logic        valid_q, valid_d;
  logic [OFS_W-1:0] addr_q, addr_d, size_q, size_d;
  free_carry_t carry_q, carry_d;
  logic        match, first, after, beyond, pred;

  assign lt_o = valid_q && (addr_q < ctl_i.hdr);

  always_comb begin
    if (ctl_i.cmd == CMD_ALLOC) begin
      match = valid_q && ({1'b0, size_q} >= ctl_i.need);
    end else begin
      match = !valid_q || (addr_q >= ctl_i.hdr);
    end
    first  = match && !carry_i.found;
    beyond = carry_i.found;
    after  = first || beyond;
    pred   = lt_o && !next_lt_i;
  end

  always_comb begin
    carry_d = carry_i;
    if (first) begin
      carry_d.found  = 1'b1;
      carry_d.fvalid = valid_q;
      carry_d.faddr  = addr_q;
      carry_d.fsize  = size_q;
    end
    if (lt_o) begin
      carry_d.pfound = 1'b1;
      carry_d.paddr  = addr_q;
      carry_d.psize  = size_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    size_d  = size_q;
    case (ctl_i.op)
      FOP_SET_FIRST: begin
        if (first) begin
          valid_d = 1'b1;
          addr_d  = ctl_i.wr_addr;
          size_d  = ctl_i.wr_size;
        end
      end
      FOP_SET_PRED: begin
        if (pred) size_d = ctl_i.wr_size;
      end
      FOP_DEL_FIRST: begin
        if (after) begin
          valid_d = next_seg_i.valid;
          addr_d  = next_seg_i.addr;
          size_d  = next_seg_i.size;
        end
      end
      FOP_SET_PRED_DEL: begin
        if (pred) size_d = ctl_i.wr_size;
        if (after) begin
          valid_d = next_seg_i.valid;
          addr_d  = next_seg_i.addr;
          size_d  = next_seg_i.size;
        end
      end
      FOP_INS_FIRST: begin
        if (beyond) begin
          valid_d = prev_seg_i.valid;
          addr_d  = prev_seg_i.addr;
          size_d  = prev_seg_i.size;
        end else if (first) begin
          valid_d = 1'b1;
          addr_d  = ctl_i.wr_addr;
          size_d  = ctl_i.wr_size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= is_head_i;
      addr_q  <= '0;
      size_q  <= OFS_W'(HEAP_BYTES - HEADER_BYTES);
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      addr_q  <= addr_d;
      size_q  <= size_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign seg_o   = '{valid: valid_q, addr: addr_q, size: size_q};

endmodule

// ----- sv/ffha_used_cell.sv -----
// ----------------------------------------------------------------------------
// ffha_used_cell
// One entry of the allocation table, with its link of the lookup carry
// chain and shift-in from the next entry on removal.
// ----------------------------------------------------------------------------
module ffha_used_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ffha_pkg::CNT_W-1:0]  idx_i,
  input  ffha_pkg::used_ctl_t         ctl_i,
  input  ffha_pkg::useg_t             next_seg_i,
  input  ffha_pkg::used_carry_t       carry_i,
  output ffha_pkg::used_carry_t       carry_o,
  output ffha_pkg::useg_t             seg_o
);
  import ffha_pkg::*;

  useg_t       seg_q, seg_d;
  used_carry_t carry_q, carry_d;
  logic        live, first, after;

  always_comb begin
    live  = idx_i < ctl_i.count;
    first = live && (seg_q.addr == ctl_i.hdr) && !carry_i.found;
    after = first || carry_i.found;
  end

  always_comb begin
    carry_d = carry_i;
    if (first) begin
      carry_d.found = 1'b1;
      carry_d.size  = seg_q.size;
    end
  end

  always_comb begin
    seg_d = seg_q;
    case (ctl_i.op)
      UOP_APPEND: begin
        if (idx_i == ctl_i.count) seg_d = '{addr: ctl_i.wr_addr, size: ctl_i.wr_size};
      end
      UOP_DEL: begin
        if (after) seg_d = next_seg_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;
  assign seg_o   = seg_q;

endmodule

// ----- sv/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with a coalescing, address-ordered free list.
// ----------------------------------------------------------------------------
// Each request is taken in idle, scanned, then decided: the free list and
// the allocation table are rows of cells, and the search result ripples
// one cell per cycle down the 257-cell free row (the 256-cell allocation
// row finishes in parallel). One request is in work at a
// time; a new one is taken as soon as the previous one has been written to
// the output register, even while that result still waits for its transfer.
module first_fit_heap_allocator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffha_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ffha_pkg::out_t out_data_o
);
  import ffha_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cmd_q;
  logic [OFS_W-1:0] req_q, pay_q, hdr;
  logic [SUM_W-1:0] need_q;
  logic [CNT_W-1:0] used_count_q, used_count_nx;
  out_t             out_q, out_nx;
  logic             out_valid_q;
  logic             apply;

  free_op_e         fop;
  used_op_e         uop;
  logic [OFS_W-1:0] fwr_addr, fwr_size;
  free_ctl_t        fctl;
  used_ctl_t        uctl;

  seg_t             fseg  [FREE_DEPTH];
  seg_t             fprev [FREE_DEPTH];
  seg_t             fnext [FREE_DEPTH];
  logic             flt   [FREE_DEPTH+1];
  free_carry_t      fc    [FREE_DEPTH+1];
  useg_t            useg  [MAX_SEGMENTS];
  useg_t            unext [MAX_SEGMENTS];
  used_carry_t      uc    [MAX_SEGMENTS+1];

  free_carry_t      fend;
  used_carry_t      uend;
  logic             free_full, mp, ms, split;
  logic [OFS_W-1:0] bsize;

  assign hdr = pay_q - OFS_W'(HEADER_BYTES);

  assign fctl = '{cmd: cmd_q, need: need_q, hdr: hdr,
                  op: apply ? fop : FOP_NONE, wr_addr: fwr_addr, wr_size: fwr_size};
  assign uctl = '{hdr: hdr, count: used_count_q, op: apply ? uop : UOP_NONE,
                  wr_addr: fend.faddr, wr_size: bsize};

  assign fc[0]           = '0;
  assign flt[FREE_DEPTH] = 1'b0;
  assign uc[0]           = '0;

  for (genvar k = 0; k < FREE_DEPTH; k++) begin : g_free
    if (k == 0) begin : g_first
      assign fprev[k] = '0;
    end else begin : g_mid
      assign fprev[k] = fseg[k-1];
    end
    if (k == FREE_DEPTH - 1) begin : g_last
      assign fnext[k] = '0;
    end else begin : g_inner
      assign fnext[k] = fseg[k+1];
    end
    ffha_free_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .is_head_i  (k == 0),
      .ctl_i      (fctl),
      .prev_seg_i (fprev[k]),
      .next_seg_i (fnext[k]),
      .next_lt_i  (flt[k+1]),
      .carry_i    (fc[k]),
      .carry_o    (fc[k+1]),
      .seg_o      (fseg[k]),
      .lt_o       (flt[k])
    );
  end

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_used
    if (k == MAX_SEGMENTS - 1) begin : g_last
      assign unext[k] = '0;
    end else begin : g_inner
      assign unext[k] = useg[k+1];
    end
    ffha_used_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (CNT_W'(k)),
      .ctl_i      (uctl),
      .next_seg_i (unext[k]),
      .carry_i    (uc[k]),
      .carry_o    (uc[k+1]),
      .seg_o      (useg[k])
    );
  end

  assign fend      = fc[FREE_DEPTH];
  assign uend      = uc[MAX_SEGMENTS];
  assign free_full = fseg[FREE_DEPTH-1].valid;

  // request decision, taken once the carry chains have settled
  always_comb begin
    fop           = FOP_NONE;
    uop           = UOP_NONE;
    fwr_addr      = hdr;
    fwr_size      = '0;
    bsize         = uend.size;
    used_count_nx = used_count_q;
    out_nx        = '{result_offset: '0, status: ST_OK};
    split = {1'b0, fend.fsize} > (need_q + SUM_W'(HEADER_BYTES));
    mp = fend.pfound &&
         ({1'b0, fend.paddr} + SUM_W'(HEADER_BYTES) + {1'b0, fend.psize} == {1'b0, hdr});
    ms = fend.found && fend.fvalid &&
         ({1'b0, hdr} + SUM_W'(HEADER_BYTES) + {1'b0, uend.size} == {1'b0, fend.faddr});
    if (cmd_q == CMD_ALLOC) begin
      bsize = split ? need_q[OFS_W-1:0] : fend.fsize;
      if (req_q == '0) begin
        out_nx.status = ST_ZERO;
      end else if (used_count_q == CNT_W'(MAX_SEGMENTS) || !fend.found) begin
        out_nx.status = ST_NOFIT;
      end else begin
        uop = UOP_APPEND;
        used_count_nx = used_count_q + CNT_W'(1);
        out_nx.result_offset = fend.faddr + OFS_W'(HEADER_BYTES);
        if (split) begin
          fop      = FOP_SET_FIRST;
          fwr_addr = OFS_W'({1'b0, fend.faddr} + SUM_W'(HEADER_BYTES) + need_q);
          fwr_size = OFS_W'({1'b0, fend.fsize} - need_q - SUM_W'(HEADER_BYTES));
        end else begin
          fop = FOP_DEL_FIRST;
        end
      end
    end else begin
      if (pay_q == '0) begin
        out_nx.status = ST_NULL;
      end else if (pay_q < OFS_W'(HEADER_BYTES) || !uend.found) begin
        out_nx.status = ST_NOTALLOC;
      end else begin
        uop = UOP_DEL;
        used_count_nx = used_count_q - CNT_W'(1);
        if (mp && ms) begin
          fop      = FOP_SET_PRED_DEL;
          fwr_size = fend.psize + OFS_W'(2 * HEADER_BYTES) + uend.size + fend.fsize;
        end else if (mp) begin
          fop      = FOP_SET_PRED;
          fwr_size = fend.psize + OFS_W'(HEADER_BYTES) + uend.size;
        end else if (free_full) begin
          fop = FOP_NONE;  // free list full: block is dropped
        end else if (ms) begin
          fop      = FOP_SET_FIRST;
          fwr_size = uend.size + OFS_W'(HEADER_BYTES) + fend.fsize;
        end else begin
          fop      = FOP_INS_FIRST;
          fwr_size = uend.size;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FREE_DEPTH - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    apply      = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_DONE: apply = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      used_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (apply) begin
        used_count_q <= used_count_nx;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= in_data_i.command;
      req_q  <= in_data_i.request_size;
      pay_q  <= in_data_i.payload_offset;
      need_q <= ({1'b0, in_data_i.request_size} + SUM_W'(GRANULE_BYTES - 1)) &
                ~SUM_W'(GRANULE_BYTES - 1);
    end
    if (apply) out_q <= out_nx;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the decision state");
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= CNT_W'(MAX_SEGMENTS))
    else $error("allocation count above table depth");
  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !apply) |=> (state_q == S_DONE))
    else $error("decision left without result transfer");
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !apply |=> $stable(used_count_q))
    else $error("allocation count changed without a decision");

endmodule
